[rtl/ukvt_pkg.sv]
// Shared constants, codes and types for the unsorted key/value table.
`default_nettype none
package ukvt_pkg;

    localparam int DEPTH       = 16;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int CAP_W       = 5;
    localparam int COUNT_W     = 5;

    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam int IN_DATA_W   = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic                  is_full;
        logic                  is_empty;
        logic [COUNT_W-1:0]    entry_count;
        logic [VALUE_BITS-1:0] removed_value;
        logic                  found;
        status_t               status;
    } result_t;

    localparam int RES_W      = $bits(result_t);
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [KEY_WIDTH-1:0]   wkey;
        logic [VALUE_WIDTH-1:0] wvalue;
        logic [ADDR_W-1:0]      raddr;
    } ram_req_t;

endpackage
`default_nettype wire

[rtl/ukvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ukvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/ukvt_ctrl.sv]
// Request sequencer: insert, scan for a key, and shift-down compaction on remove.
`default_nettype none
module ukvt_ctrl (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ukvt_pkg::CAP_W-1:0]      cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ukvt_pkg::REQ_W-1:0]      in_req,
    input  wire logic [ukvt_pkg::KEY_BITS-1:0]   in_key,
    input  wire logic [ukvt_pkg::VALUE_BITS-1:0] in_value,
    output ukvt_pkg::ram_req_t                   ram_req,
    input  wire logic [ukvt_pkg::KEY_WIDTH-1:0]  rd_key,
    input  wire logic [ukvt_pkg::VALUE_WIDTH-1:0] rd_value,
    output logic                                 res_valid,
    input  wire logic                            res_ready,
    output ukvt_pkg::result_t                    res
);
    import ukvt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    req_t                   req_reg, req_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   pend_reg, pend_next;
    logic [ADDR_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                   hit_reg, hit_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] removed_reg, removed_next;
    status_t                status_reg, status_next;

    logic in_fire;
    logic rd_more;
    logic full;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign rd_more   = (rd_idx_reg < count_reg);
    assign full      = (CMP_W'(count_reg) >= CMP_W'(cap_reg)) || (count_reg >= CNT_W'(DEPTH));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        cap_next      = cap_reg;
        key_next      = key_reg;
        req_next      = req_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;

        ram_req        = '0;
        ram_req.raddr  = rd_idx_reg[ADDR_W-1:0];

        res_valid = 1'b0;

        if (cfg_valid) begin
            cap_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    key_next     = in_key[KEY_WIDTH-1:0];
                    req_next     = req_t'(in_req);
                    hit_next     = 1'b0;
                    removed_next = '0;
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    status_next  = ST_OK;
                    unique case (req_t'(in_req))
                        REQ_INSERT: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_req.we     = 1'b1;
                                ram_req.waddr  = count_reg[ADDR_W-1:0];
                                ram_req.wkey   = in_key[KEY_WIDTH-1:0];
                                ram_req.wvalue = in_value[VALUE_WIDTH-1:0];
                                count_next     = count_reg + 1'b1;
                            end
                            state_next = S_DONE;
                        end
                        REQ_LOOKUP, REQ_REMOVE: begin
                            state_next = S_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_more) begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[ADDR_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && (rd_key == key_reg)) begin
                    hit_next = 1'b1;
                    pos_next = pend_idx_reg;
                    if (req_reg == REQ_REMOVE) begin
                        removed_next = rd_value;
                    end
                end
                if (!rd_more && !pend_reg) begin
                    if (!hit_reg) begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end else if (req_reg == REQ_REMOVE) begin
                        rd_idx_next = CNT_W'(pos_reg) + 1'b1;
                        state_next  = S_SHIFT;
                    end else begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (rd_more) begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg[ADDR_W-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                // move the entry read last cycle one slot down
                if (pend_reg) begin
                    ram_req.we     = 1'b1;
                    ram_req.waddr  = pend_idx_reg - 1'b1;
                    ram_req.wkey   = rd_key;
                    ram_req.wvalue = rd_value;
                end
                if (!rd_more && !pend_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res.status        = status_reg;
        res.found         = hit_reg;
        res.removed_value = VALUE_BITS'(removed_reg);
        res.entry_count   = COUNT_W'(count_reg);
        res.is_empty      = (count_reg == '0);
        res.is_full       = full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CAP_W'(16);
            pend_reg  <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            cap_reg   <= cap_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
        end
        key_reg      <= key_next;
        req_reg      <= req_next;
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_pend_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (rd_idx_reg == CNT_W'(pend_idx_reg) + 1'b1))
        else $error("read pipeline index out of step");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_req.we && (state_reg == S_SHIFT)) |-> (CNT_W'(ram_req.waddr) < count_reg))
        else $error("shift write beyond stored entries");

    a_remove_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT && state_next == S_DONE) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not decrement count");

    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.found) |-> (res.status == ST_OK))
        else $error("found result with error status");

endmodule
`default_nettype wire

[rtl/unsorted_key_value_table.sv]
// Top level: stream ports, key and value memories, result output register.
//
// Unsorted key/value table, DEPTH entries kept in insertion order.
// Input items (s_*): tuser carries the request (0 insert, 1 lookup,
// 2 remove, 3 no-op); tdata carries key and value. One result item (m_*)
// follows every input item, in order.
// cfg_valid/cfg_data writes the capacity limit; write it only while idle.
// One item is worked at a time. An insert or no-op goes from accept
// through the DONE state and the output register to m_tvalid. A lookup
// or remove scans all stored entries through the key memory read port,
// one entry per cycle. A remove that hits then moves every later entry
// down one slot, one per cycle through the same port.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, the following result is held inside
// and s_tready stays low until the output register frees.
// Reset clears the count (table empty) and sets capacity to 16; memory
// contents are left as they are and are never read before being written.
`default_nettype none
module unsorted_key_value_table (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ukvt_pkg::CAP_W-1:0]          cfg_data,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ukvt_pkg::IN_DATA_W-1:0]      s_tdata,  // key, value
    input  wire logic [ukvt_pkg::REQ_W-1:0]          s_tuser,  // req_type
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // status, found, removed_value, entry_count, is_empty, is_full
    output logic      [ukvt_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import ukvt_pkg::*;

    ram_req_t               ram_req;
    logic [KEY_WIDTH-1:0]   rd_key;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic                   res_valid;
    logic                   res_ready;
    result_t                res;

    logic                   m_valid_reg, m_valid_next;
    result_t                m_res_reg, m_res_next;

    ukvt_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (s_tuser),
        .in_key    (s_tdata[KEY_BITS-1:0]),
        .in_value  (s_tdata[KEY_BITS +: VALUE_BITS]),
        .ram_req   (ram_req),
        .rd_key    (rd_key),
        .rd_value  (rd_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ukvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wkey),
        .raddr (ram_req.raddr),
        .rdata (rd_key)
    );

    ukvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_value_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wvalue),
        .raddr (ram_req.raddr),
        .rdata (rd_value)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'(m_res_reg);

endmodule
`default_nettype wire
